// ----- hdl/matrix_inverse_4x4_top_defines.svh -----
// Assertion macros used by the matrix inverse sequencer (mi4_ctrl).
`ifndef MATRIX_INVERSE_4X4_TOP_DEFINES_SVH
`define MATRIX_INVERSE_4X4_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define MI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the following cycle.
`define MI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/mi4_pkg.sv -----
// ---------------------------------------------------------------------------
// mi4_pkg
// Types and constants shared by the 4x4 matrix inverse block.
// ---------------------------------------------------------------------------
package mi4_pkg;
	localparam int MATRIX_DIM_DEF = 4;
	localparam int CELLS = 16;
	localparam int ELEM_W = 16;
	localparam int COF_W = 52;
	localparam int DET_W = 128;
	localparam int RES_W = 32;
	localparam int IDX_W = 4;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_COF  = 3'd1,
		OP_DET  = 3'd2,
		OP_DIV  = 3'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [1:0]       step;
		logic             div_start;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic sing;
	} stat_t;
endpackage

// ----- hdl/mi4_div.sv -----
// ---------------------------------------------------------------------------
// mi4_div
// Radix-2 restoring divider: 76-bit magnitude over a 128-bit divisor, one
// quotient bit per cycle, with saturation to the Q16.16 range.
// ---------------------------------------------------------------------------
module mi4_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [75:0]                 num,
	input  logic [mi4_pkg::DET_W-1:0]   den,
	input  logic                        neg,
	output logic                        done,
	output logic [mi4_pkg::RES_W-1:0]   quot,
	output logic                        ovf
);
	import mi4_pkg::*;

	logic [DET_W-1:0] rem_q;
	logic [75:0]      num_q;
	logic [75:0]      quo_q;
	logic [6:0]       cnt_q;
	logic             busy_q;
	logic             neg_q;
	logic [DET_W:0]   shifted;
	logic [DET_W:0]   diff;
	logic [31:0]      lim;

	assign shifted = {rem_q, num_q[75]};
	assign diff = shifted - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd75) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// The sign is held with the operands, since the inputs move on to the
	// next word while the result is still being read.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			quo_q <= '0;
			neg_q <= neg;
		end else if (busy_q) begin
			num_q <= {num_q[74:0], 1'b0};
			if (!diff[DET_W]) begin
				rem_q <= diff[DET_W-1:0];
				quo_q <= {quo_q[74:0], 1'b1};
			end else begin
				rem_q <= shifted[DET_W-1:0];
				quo_q <= {quo_q[74:0], 1'b0};
			end
		end
	end

	assign lim = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
	always_comb begin
		ovf = (quo_q[75:32] != '0) || (quo_q[31:0] > lim);
		quot = ovf ? lim : quo_q[31:0];
		if (neg_q) quot = 32'd0 - quot;
	end
endmodule

// ----- hdl/mi4_datapath.sv -----
// ---------------------------------------------------------------------------
// mi4_datapath
// Element store, cofactor unit (one product term per cycle), determinant
// accumulator and shared divider.
// ---------------------------------------------------------------------------
module mi4_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic [mi4_pkg::IDX_W-1:0]       load_idx,
	input  logic signed [mi4_pkg::ELEM_W-1:0] element_value,
	input  mi4_pkg::cmd_t                   cmd,
	output mi4_pkg::stat_t                  stat,
	output logic [mi4_pkg::RES_W-1:0]       quot,
	output logic                            ovf
);
	import mi4_pkg::*;

	logic signed [ELEM_W-1:0] mat_q [CELLS];
	logic signed [COF_W-1:0]  cof_q [CELLS];
	logic signed [DET_W-1:0]  det_q;
	logic signed [COF_W-1:0]  acc_q;
	logic signed [2*ELEM_W-1:0] p1_s1;
	logic signed [ELEM_W-1:0] e3_s1;
	logic                     p_vld_s1;
	logic [1:0]               p_step_s1;
	logic [IDX_W-1:0]         p_idx_s1;
	logic                     p_neg_s1;
	logic signed [COF_W-1:0]  term;
	logic [1:0] cs [3];
	logic [1:0] rs [3];
	logic [1:0] cc, rr, x;
	logic signed [ELEM_W-1:0] ea, eb, ec, ed, ee, ef;
	logic signed [DET_W-1:0]  dprod;
	logic signed [COF_W+ELEM_W-1:0] dprod_n;
	logic signed [COF_W-1:0]  kdet;
	logic signed [COF_W-1:0]  kd;
	logic [DET_W-1:0]         dmag;
	logic [COF_W-1:0]         kmag;
	logic                     div_done;

	always_ff @(posedge clk) begin
		if (load) mat_q[load_idx] <= element_value;
	end

	// Remaining columns and rows of the 3x3 minor of element idx.
	assign cc = cmd.idx[3:2];
	assign rr = cmd.idx[1:0];
	assign x = cmd.step;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cs[i] = (2'(i) >= cc) ? 2'(i + 1) : 2'(i);
			rs[i] = (2'(i) >= rr) ? 2'(i + 1) : 2'(i);
		end
		// Sarrus diagonal x: positive uses rows (x+y)%3, negative (x-y)%3.
		ea = mat_q[{cs[0], rs[x]}];
		eb = mat_q[{cs[1], rs[(x == 2'd2) ? 2'd0 : x + 2'd1]}];
		ec = mat_q[{cs[2], rs[(x == 2'd0) ? 2'd2 : x - 2'd1]}];
		ed = mat_q[{cs[0], rs[x]}];
		ee = mat_q[{cs[1], rs[(x == 2'd0) ? 2'd2 : x - 2'd1]}];
		ef = mat_q[{cs[2], rs[(x == 2'd2) ? 2'd0 : x + 2'd1]}];
	end

	// Two pipeline steps: the triple product is split as a*b then *c; the
	// positive and negative diagonals run side by side.
	logic signed [2*ELEM_W-1:0] pa, pb;
	logic signed [ELEM_W-1:0] ca, cb;
	logic signed [2*ELEM_W-1:0] pn_s1;
	logic signed [ELEM_W-1:0] en_s1;
	assign pa = ea * eb;
	assign ca = ec;
	assign pb = ed * ee;
	assign cb = ef;

	always_ff @(posedge clk) begin
		p1_s1 <= pa;
		e3_s1 <= ca;
		pn_s1 <= pb;
		en_s1 <= cb;
		p_step_s1 <= cmd.step;
		p_idx_s1 <= cmd.idx;
		p_neg_s1 <= cmd.idx[0] ^ cmd.idx[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) p_vld_s1 <= 1'b0;
		else p_vld_s1 <= (cmd.op == OP_COF);
	end

	assign term = COF_W'(p1_s1 * e3_s1) - COF_W'(pn_s1 * en_s1);

	always_ff @(posedge clk) begin
		if (p_vld_s1) begin
			if (p_step_s1 == 2'd0) acc_q <= term;
			else acc_q <= acc_q + term;
			if (p_step_s1 == 2'd2)
				cof_q[p_idx_s1] <= p_neg_s1 ? -(acc_q + term) : (acc_q + term);
		end
	end

	// Determinant: one first-column term per cycle.
	assign kdet = cof_q[{2'd0, cmd.step}];
	assign dprod_n = kdet * mat_q[{2'd0, cmd.step}];
	assign dprod = DET_W'(dprod_n);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) det_q <= '0;
		else if (cmd.op == OP_DET) begin
			if (cmd.step == 2'd0) det_q <= dprod;
			else det_q <= det_q + dprod;
		end
	end

	assign dmag = det_q[DET_W-1] ? -det_q : det_q;
	// Adjugate entry for output (c, r) is cofactor at (r, c).
	always_comb begin
		kd = cof_q[{cmd.idx[1:0], cmd.idx[3:2]}];
	end
	assign kmag = kd[COF_W-1] ? COF_W'(-kd) : COF_W'(kd);

	mi4_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num({kmag, 24'd0}), .den(dmag),
		.neg(kd[COF_W-1] ^ det_q[DET_W-1]),
		.done(div_done), .quot(quot), .ovf(ovf)
	);

	assign stat.div_done = div_done;
	assign stat.sing = (det_q == '0);
endmodule

// ----- hdl/mi4_ctrl.sv -----
// ---------------------------------------------------------------------------
// mi4_ctrl
// Sequencer: loads words, steps cofactors and determinant, runs divisions.
// ---------------------------------------------------------------------------
module mi4_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	output logic                      load,
	output logic [mi4_pkg::IDX_W-1:0] load_idx,
	output mi4_pkg::cmd_t             cmd,
	input  mi4_pkg::stat_t            stat,
	output logic                      emit,
	output logic [mi4_pkg::IDX_W-1:0] emit_idx,
	output logic                      emit_sing
);
	import mi4_pkg::*;
	`include "matrix_inverse_4x4_top_defines.svh"

	typedef enum logic [5:0] {
		S_LOAD = 6'b000001,
		S_COF  = 6'b000010,
		S_DRN  = 6'b000100,
		S_DET  = 6'b001000,
		S_DIV  = 6'b010000,
		S_WAIT = 6'b100000
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] cnt_q;
	logic [1:0]       step_q;

	assign busy = (state_q != S_LOAD);
	assign load = start && !busy;
	assign load_idx = cnt_q;

	always_comb begin
		cmd = '0;
		cmd.idx = cnt_q;
		cmd.step = step_q;
		unique case (state_q)
			S_COF:  cmd.op = OP_COF;
			S_DET:  cmd.op = OP_DET;
			S_DIV:  cmd.div_start = 1'b1;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q <= '0;
			step_q <= '0;
			emit <= 1'b0;
			emit_idx <= '0;
			emit_sing <= 1'b0;
		end else begin
			emit <= 1'b0;
			unique case (state_q)
				S_LOAD: if (load) begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_q <= S_COF;
				end
				S_COF: begin
					step_q <= (step_q == 2'd2) ? 2'd0 : step_q + 2'd1;
					if (step_q == 2'd2) begin
						cnt_q <= cnt_q + 4'd1;
						if (cnt_q == 4'd15) state_q <= S_DRN;
					end
				end
				S_DRN: begin
					step_q <= 2'd0;
					state_q <= S_DET;
				end
				S_DET: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) state_q <= S_DIV;
				end
				S_DIV: begin
					if (stat.sing) begin
						emit <= 1'b1;
						emit_idx <= cnt_q;
						emit_sing <= 1'b1;
						cnt_q <= cnt_q + 4'd1;
						if (cnt_q == 4'd15) state_q <= S_LOAD;
					end else state_q <= S_WAIT;
				end
				S_WAIT: if (stat.div_done) begin
					emit <= 1'b1;
					emit_idx <= cnt_q;
					emit_sing <= 1'b0;
					cnt_q <= cnt_q + 4'd1;
					state_q <= (cnt_q == 4'd15) ? S_LOAD : S_DIV;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	`MI_ASSERT_IMP(a_load_idle, clk, arst_n, load, state_q == S_LOAD)
	`MI_ASSERT_NEXT(a_det_after, clk, arst_n, state_q == S_DRN, state_q == S_DET)
	`MI_ASSERT_IMP(a_emit_busy, clk, arst_n, emit && emit_idx != 4'd15, busy)
endmodule

// ----- hdl/matrix_inverse_4x4_top.sv -----
// ---------------------------------------------------------------------------
// matrix_inverse_4x4_top
// 4x4 matrix inverse by adjugate over exact determinant, Q8.8 in, Q16.16 out.
// ---------------------------------------------------------------------------
// channel  | handshake          | payload
// input    | start / busy       | element_value
// result   | strobe             | inverse_value, element_index, last, singular, overflow
// Sixteen words load one per cycle while start is held. Then cofactor terms are
// stepped and the determinant set up; each result runs through the serial
// divider, unless singular. busy is high from the sixteenth word to the last
// result. Reset clears the sequencer; results cannot be stalled.
module matrix_inverse_4x4_top #(
	parameter int MATRIX_DIM = mi4_pkg::MATRIX_DIM_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [mi4_pkg::ELEM_W-1:0]  element_value,
	output logic                               strobe,
	output logic signed [mi4_pkg::RES_W-1:0]   inverse_value,
	output logic [mi4_pkg::IDX_W-1:0]          element_index,
	output logic                               last,
	output logic                               singular,
	output logic                               overflow
);
	import mi4_pkg::*;

	cmd_t             cmd;
	stat_t            stat;
	logic             load, emit, emit_sing, dovf;
	logic [IDX_W-1:0] load_idx, emit_idx;
	logic [RES_W-1:0] quot;

	mi4_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.load(load), .load_idx(load_idx), .cmd(cmd), .stat(stat),
		.emit(emit), .emit_idx(emit_idx), .emit_sing(emit_sing)
	);

	mi4_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .load(load), .load_idx(load_idx),
		.element_value(element_value), .cmd(cmd), .stat(stat),
		.quot(quot), .ovf(dovf)
	);

	// Divider result holds after done, so it is valid in the strobe cycle.
	assign strobe = emit && (MATRIX_DIM == 4);
	assign inverse_value = emit_sing ? '0 : quot;
	assign overflow = emit_sing ? 1'b0 : dovf;
	assign element_index = emit_idx;
	assign last = (emit_idx == 4'd15);
	assign singular = emit_sing;
endmodule

// ----- dv/matrix_inverse_4x4_top_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// matrix_inverse_4x4_top_tb
// Loads 4x4 Q8.8 matrices word by word and checks every Q16.16 inverse word,
// its index, last, singular and overflow flags against an exact predictor.
// ---------------------------------------------------------------------------
module matrix_inverse_4x4_top_tb;
	import mi4_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 200;

	typedef struct {
		logic signed [RES_W-1:0] value;
		logic [IDX_W-1:0]        index;
		logic                    last;
		logic                    singular;
		logic                    overflow;
	} inv_word_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic signed [ELEM_W-1:0] element_value;
	logic                     strobe;
	logic signed [RES_W-1:0]  inverse_value;
	logic [IDX_W-1:0]         element_index;
	logic                     last;
	logic                     singular;
	logic                     overflow;

	inv_word_t          inverse_queue[$];
	logic signed [15:0] loaded[CELLS];
	int                 load_pos;
	int                 errors;
	int                 idle_cycles;
	bit                 no_gaps;

	matrix_inverse_4x4_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.element_value(element_value),
		.strobe(strobe),
		.inverse_value(inverse_value),
		.element_index(element_index),
		.last(last),
		.singular(singular),
		.overflow(overflow)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Minor of the element at column cc, row rr, by Sarrus on the 3x3 rest.
	function automatic longint minor_at(int cc, int rr);
		longint sub[3][3];
		longint acc;
		longint pos;
		longint neg;
		int ci;
		int ri;
		acc = 0;
		ci = 0;
		for (int c = 0; c < 4; c++) begin
			if (c != cc) begin
				ri = 0;
				for (int r = 0; r < 4; r++) begin
					if (r != rr) begin
						sub[ci][ri] = longint'(loaded[c*4+r]);
						ri++;
					end
				end
				ci++;
			end
		end
		for (int x = 0; x < 3; x++) begin
			pos = 1;
			neg = 1;
			for (int y = 0; y < 3; y++) begin
				pos *= sub[(x+y)%3][y];
				neg *= sub[(3+x-y)%3][y];
			end
			acc += pos - neg;
		end
		return acc;
	endfunction

	// Full inverse of the loaded matrix, pushed as sixteen expected words.
	task automatic predict_inverse();
		longint                cof[CELLS];
		logic signed [127:0]   det;
		logic [127:0]          dmag;
		logic [127:0]          kmag;
		logic [127:0]          quo;
		logic [127:0]          lim;
		logic                  neg;
		longint                k;
		inv_word_t             w;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				cof[c*4+r] = ((r + c) & 1) ? -minor_at(c, r) : minor_at(c, r);
		det = '0;
		for (int r = 0; r < 4; r++)
			det += 128'(signed'(loaded[r])) * 128'(signed'(cof[r]));
		dmag = det[127] ? -det : det;
		for (int p = 0; p < CELLS; p++) begin
			w.value    = '0;
			w.overflow = 1'b0;
			w.index    = p[IDX_W-1:0];
			w.last     = (p == CELLS - 1);
			w.singular = (det == 0);
			if (det != 0) begin
				k    = cof[(p % 4) * 4 + p / 4];
				kmag = (k < 0) ? 128'(-k) : 128'(k);
				neg  = (k < 0) != det[127];
				quo  = (kmag << 24) / dmag;
				lim  = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
				if (quo > lim) begin
					w.overflow = 1'b1;
					quo = lim;
				end
				w.value = neg ? -quo[31:0] : quo[31:0];
			end
			inverse_queue.push_back(w);
		end
	endtask

	// Sends one element word; the gap before it is random unless gaps are off.
	task automatic send_element(logic signed [15:0] val);
		while (!no_gaps && $urandom_range(99) < 19) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start         <= 1'b1;
		element_value <= val;
		while (busy) @(negedge clk);
		// busy is low and stable here, so the word is taken at the coming
		// rising edge.
		loaded[load_pos] = val;
		load_pos = (load_pos + 1) % CELLS;
		if (load_pos == 0) predict_inverse();
		@(negedge clk);
	endtask

	task automatic send_matrix(logic signed [15:0] mat[CELLS]);
		for (int i = 0; i < CELLS; i++) send_element(mat[i]);
	endtask

	function automatic logic signed [15:0] rand_elem(int kind);
		case (kind)
			0: return 16'($urandom);
			1: return 16'($urandom_range(1023)) - 16'sd512;
			2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			default: return 16'($urandom_range(7)) - 16'sd4;
		endcase
	endfunction

	// Random matrix: plain, a repeated column (singular) or a column that
	// nearly repeats another, which drives the inverse toward saturation.
	task automatic random_matrix(int shape);
		logic signed [15:0] mat[CELLS];
		int kind;
		int src;
		int dst;
		kind = $urandom_range(3);
		for (int i = 0; i < CELLS; i++) mat[i] = rand_elem(kind);
		src = $urandom_range(3);
		dst = (src + 1 + $urandom_range(2)) % 4;
		if (shape == 1) begin
			for (int r = 0; r < 4; r++) mat[dst*4+r] = mat[src*4+r];
		end else if (shape == 2) begin
			for (int r = 0; r < 4; r++) mat[dst*4+r] = mat[src*4+r];
			mat[dst*4 + $urandom_range(3)] += 16'sd1;
		end
		send_matrix(mat);
	endtask

	task automatic test_identity_and_extremes();
		logic signed [15:0] mat[CELLS];
		for (int i = 0; i < CELLS; i++) mat[i] = (i % 5 == 0) ? 16'sd256 : 16'sd0;
		send_matrix(mat);
		// Opposite full-scale values on both diagonals, ones elsewhere.
		for (int i = 0; i < CELLS; i++)
			mat[i] = (i % 5 == 0) ? 16'sh8000 : ((i % 3 == 0) ? 16'sh7FFF : 16'sd1);
		send_matrix(mat);
	endtask

	task automatic test_singular_zero();
		logic signed [15:0] mat[CELLS];
		for (int i = 0; i < CELLS; i++) mat[i] = 16'sd0;
		send_matrix(mat);
	endtask

	task automatic test_overflow();
		logic signed [15:0] mat[CELLS];
		for (int i = 0; i < CELLS; i++) mat[i] = (i % 5 == 0) ? 16'sd1 : 16'sd0;
		mat[0] = 16'sh7FFF;
		mat[1] = 16'sh7FFF;
		mat[4] = 16'sh7FFE;
		mat[5] = 16'sh7FFF;
		send_matrix(mat);
	endtask

	task automatic test_random();
		for (int m = 0; m < 12; m++) begin
			no_gaps = (m >= 4 && m < 7);
			random_matrix($urandom_range(2));
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (inverse_queue.size() == 0) begin
				$display("%0t: unexpected word idx=%0d value=%0d", $time,
					element_index, inverse_value);
				errors++;
			end else begin
				inv_word_t w;
				w = inverse_queue.pop_front();
				if (inverse_value !== w.value || element_index !== w.index ||
					last !== w.last || singular !== w.singular ||
					overflow !== w.overflow) begin
					$display("%0t: mismatch exp val=%0d idx=%0d last=%0b sing=%0b ovf=%0b",
						$time, w.value, w.index, w.last, w.singular, w.overflow);
					$display("%0t:          act val=%0d idx=%0d last=%0b sing=%0b ovf=%0b",
						$time, inverse_value, element_index, last, singular, overflow);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog timeout", $time);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		element_value = '0;
		errors        = 0;
		idle_cycles   = 0;
		load_pos      = 0;
		no_gaps       = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_identity_and_extremes();
		test_singular_zero();
		test_overflow();
		test_random();
		start <= 1'b0;
		while (inverse_queue.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && inverse_queue.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
